// ===== design/nnis_pkg.sv =====
`default_nettype none
package nnis_pkg;

  localparam int unsigned SRC_STORE_DEPTH_DEF = 16384;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned LIDX_W  = 14;
  localparam int unsigned DST_W   = 10;
  localparam int unsigned SDIM_W  = 8;
  localparam int unsigned DDIM_W  = 11;
  localparam int unsigned NUM_W   = DST_W + SDIM_W;   // dst coord times source size
  localparam int unsigned FIDX_W  = 2 * SDIM_W + 1;   // full computed source index
  localparam int unsigned ADDR_MAX_W = 20;            // enough for the largest store

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DDIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic              v;
    logic              kind;
    logic [LIDX_W-1:0] lidx;
    logic [PIX_W-1:0]  pix;
    logic [DST_W-1:0]  dx;
    logic [DST_W-1:0]  dy;
    logic              oor;
    logic [NUM_W-1:0]  rx;
    logic [NUM_W-1:0]  ry;
    logic [SDIM_W-1:0] qx;
    logic [SDIM_W-1:0] qy;
    logic [FIDX_W-1:0] idx;
  } stg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [LIDX_W-1:0] idx;
    logic              oor;
  } res_t;

endpackage
`default_nettype wire

// ===== design/nnis_ram.sv =====
`default_nettype none
module nnis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/nearest_neighbour_image_scaler_core.sv =====
// Nearest-neighbor scaler: fully pipelined, one request per clock sustained unless the output skid is full.
// Each request passes an input register, multiply, eight restoring-divide stages,
// index multiply, index add and the store read, then the output register.
// Stalls freeze the pipeline only once the two-entry output skid is full.
// Reset (async, active low) clears valid bits and sets all size registers to 1;
// the pixel store is not cleared.
`default_nettype none
module nearest_neighbour_image_scaler_core #(
  parameter int unsigned SRC_STORE_DEPTH = nnis_pkg::SRC_STORE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [nnis_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [nnis_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               kind_i,
  input  wire logic [nnis_pkg::LIDX_W-1:0]        load_index_i,
  input  wire logic [nnis_pkg::PIX_W-1:0]         pixel_in_i,
  input  wire logic [nnis_pkg::DST_W-1:0]         dst_x_i,
  input  wire logic [nnis_pkg::DST_W-1:0]         dst_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [nnis_pkg::PIX_W-1:0]              pixel_out_o,
  output logic [nnis_pkg::LIDX_W-1:0]             source_index_o,
  output logic                                    out_of_range_o
);
  import nnis_pkg::*;

  localparam int unsigned AW     = (SRC_STORE_DEPTH > 1) ? $clog2(SRC_STORE_DEPTH) : 1;
  localparam int unsigned NSTG   = 13;
  localparam int unsigned DIV0   = 2;  // first divide stage
  localparam logic [ADDR_MAX_W:0] DEPTH_V = (ADDR_MAX_W + 1)'(SRC_STORE_DEPTH);

  // config registers
  logic [SDIM_W-1:0] src_w_q, src_h_q;
  logic [DDIM_W-1:0] dst_w_q, dst_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SDIM_W'(1);
      src_h_q <= SDIM_W'(1);
      dst_w_q <= DDIM_W'(1);
      dst_h_q <= DDIM_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i[SDIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i[SDIM_W-1:0];
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline
  stg_t pipe_q [NSTG];
  stg_t pipe_d [NSTG];
  logic en;
  logic skid_v_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_comb begin
    pipe_d[0]      = pipe_q[0];
    pipe_d[0].v    = in_valid_i;
    pipe_d[0].kind = kind_i;
    pipe_d[0].lidx = load_index_i;
    pipe_d[0].pix  = pixel_in_i;
    pipe_d[0].dx   = dst_x_i;
    pipe_d[0].dy   = dst_y_i;
  end

  // range check and numerators
  always_comb begin
    pipe_d[1] = pipe_q[0];
    if (pipe_q[0].kind == KIND_LOAD) begin
      pipe_d[1].oor = !({{(ADDR_MAX_W + 1 - LIDX_W){1'b0}}, pipe_q[0].lidx} < DEPTH_V);
    end else begin
      pipe_d[1].oor = ({1'b0, pipe_q[0].dx} >= dst_w_q) || ({1'b0, pipe_q[0].dy} >= dst_h_q);
    end
    pipe_d[1].rx = pipe_q[0].dx * src_w_q;
    pipe_d[1].ry = pipe_q[0].dy * src_h_q;
    pipe_d[1].qx = '0;
    pipe_d[1].qy = '0;
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar s = 0; s < SDIM_W; s++) begin : g_div
    localparam int unsigned B = SDIM_W - 1 - s;
    logic [NUM_W:0] dsx, dsy;
    assign dsx = {{(NUM_W + 1 - DDIM_W){1'b0}}, dst_w_q} << B;
    assign dsy = {{(NUM_W + 1 - DDIM_W){1'b0}}, dst_h_q} << B;
    always_comb begin
      pipe_d[DIV0+s] = pipe_q[DIV0+s-1];
      if ({1'b0, pipe_q[DIV0+s-1].rx} >= dsx) begin
        pipe_d[DIV0+s].rx    = pipe_q[DIV0+s-1].rx - dsx[NUM_W-1:0];
        pipe_d[DIV0+s].qx[B] = 1'b1;
      end
      if ({1'b0, pipe_q[DIV0+s-1].ry} >= dsy) begin
        pipe_d[DIV0+s].ry    = pipe_q[DIV0+s-1].ry - dsy[NUM_W-1:0];
        pipe_d[DIV0+s].qy[B] = 1'b1;
      end
    end
  end

  localparam int unsigned SMUL = DIV0 + SDIM_W;  // 10
  localparam int unsigned SADD = SMUL + 1;       // 11
  localparam int unsigned SMEM = SADD + 1;       // 12

  always_comb begin
    pipe_d[SMUL]     = pipe_q[SMUL-1];
    pipe_d[SMUL].idx = FIDX_W'(pipe_q[SMUL-1].qy * src_w_q);
  end

  always_comb begin
    pipe_d[SADD]     = pipe_q[SADD-1];
    pipe_d[SADD].idx = pipe_q[SADD-1].idx + FIDX_W'(pipe_q[SADD-1].qx);
  end

  // store access: loads write, fetches read, same stage keeps order
  logic                  mem_we, mem_re, idx_oob;
  logic [ADDR_MAX_W-1:0] waddr_x, raddr_x;
  logic [PIX_W-1:0]      rdata;

  assign idx_oob = !({{(ADDR_MAX_W + 1 - FIDX_W){1'b0}}, pipe_q[SADD].idx} < DEPTH_V);
  assign waddr_x = {{(ADDR_MAX_W - LIDX_W){1'b0}}, pipe_q[SADD].lidx};
  assign raddr_x = {{(ADDR_MAX_W - FIDX_W){1'b0}}, pipe_q[SADD].idx};
  assign mem_we  = en && pipe_q[SADD].v && (pipe_q[SADD].kind == KIND_LOAD) && !pipe_q[SADD].oor;
  assign mem_re  = en && pipe_q[SADD].v && (pipe_q[SADD].kind == KIND_FETCH);

  always_comb begin
    pipe_d[SMEM] = pipe_q[SADD];
    if (pipe_q[SADD].kind == KIND_FETCH) begin
      pipe_d[SMEM].oor = pipe_q[SADD].oor || idx_oob;
    end
  end

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SRC_STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_x[AW-1:0]),
    .wdata_i (pipe_q[SADD].pix),
    .re_i    (mem_re),
    .raddr_i (raddr_x[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        pipe_q[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < NSTG; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  // result of the last stage; an in-range load makes none
  logic res_v;
  res_t res;

  assign res_v   = pipe_q[SMEM].v && ((pipe_q[SMEM].kind == KIND_FETCH) || pipe_q[SMEM].oor);
  assign res.oor = pipe_q[SMEM].oor;
  assign res.pix = pipe_q[SMEM].oor ? '0 : rdata;
  assign res.idx = pipe_q[SMEM].oor ? '0 : pipe_q[SMEM].idx[LIDX_W-1:0];

  // output register plus skid entry
  logic out_v_q;
  res_t out_q, skid_q;
  logic consume, incoming;

  assign consume  = out_v_q && !out_stall_i;
  assign incoming = en && res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (consume) begin
        skid_v_q <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_v_q || consume) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (consume) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (consume) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (!out_v_q || consume) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign pixel_out_o    = out_q.pix;
  assign source_index_o = out_q.idx;
  assign out_of_range_o = out_q.oor;

endmodule
`default_nettype wire

// ===== bench/nearest_neighbour_image_scaler_core_tb.sv =====
`timescale 1ns / 100ps
module nearest_neighbour_image_scaler_core_tb;
  import nnis_pkg::*;

  localparam int unsigned STORE_DEPTH = SRC_STORE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic              kind;
    logic [LIDX_W-1:0] lidx;
    logic [PIX_W-1:0]  pix;
    logic [DST_W-1:0]  dx;
    logic [DST_W-1:0]  dy;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [LIDX_W-1:0] load_index = '0;
  logic [PIX_W-1:0] pixel_in = '0;
  logic [DST_W-1:0] dst_x = '0;
  logic [DST_W-1:0] dst_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic [LIDX_W-1:0] source_index;
  logic out_of_range;

  nearest_neighbour_image_scaler_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .load_index_i(load_index), .pixel_in_i(pixel_in),
    .dst_x_i(dst_x), .dst_y_i(dst_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_out_o(pixel_out), .source_index_o(source_index),
    .out_of_range_o(out_of_range)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // size registers as the block should hold them
  int unsigned src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;
  logic [PIX_W-1:0] scaler_pixels [STORE_DEPTH];
  bit written [STORE_DEPTH];
  request_t pending_requests [$];
  res_t expected_pixels [$];
  bit holding = 1'b0;
  int errors = 0;
  bit any_accept;

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // returns 1 with the source index when the fetch reads the store
  function automatic bit map_to_source(input logic [DST_W-1:0] x, input logic [DST_W-1:0] y,
                                       output int unsigned idx);
    int unsigned sx, sy;
    idx = 0;
    if (x >= dst_w || y >= dst_h) return 0;
    sx = (x * src_w) / dst_w;
    sy = (y * src_h) / dst_h;
    idx = sy * src_w + sx;
    return idx < STORE_DEPTH;
  endfunction

  function automatic void predict_pixel(input request_t rq);
    int unsigned idx;
    res_t r;
    if (rq.kind == KIND_LOAD) begin
      scaler_pixels[rq.lidx] = rq.pix;
      return;
    end
    r = '{pix: '0, idx: '0, oor: 1'b1};
    if (map_to_source(rq.dx, rq.dy, idx)) begin
      r.pix = scaler_pixels[idx];
      r.idx = idx[LIDX_W-1:0];
      r.oor = 1'b0;
    end
    expected_pixels.push_back(r);
  endfunction

  task automatic queue_load(input int unsigned i, input logic [PIX_W-1:0] p);
    request_t rq;
    rq = '{kind: KIND_LOAD, lidx: i[LIDX_W-1:0], pix: p,
           dx: DST_W'($urandom), dy: DST_W'($urandom)};
    written[i] = 1'b1;
    pending_requests.push_back(rq);
  endtask

  // loads the mapped entry first if it was never written
  task automatic queue_fetch(input int unsigned x, input int unsigned y);
    request_t rq;
    int unsigned idx;
    rq = '{kind: KIND_FETCH, lidx: LIDX_W'($urandom), pix: $urandom,
           dx: x[DST_W-1:0], dy: y[DST_W-1:0]};
    if (map_to_source(rq.dx, rq.dy, idx) && !written[idx]) queue_load(idx, $urandom);
    pending_requests.push_back(rq);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || holding || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input int unsigned v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= v[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (i)
      REG_SRC_WIDTH:  src_w = v & 8'hFF;
      REG_SRC_HEIGHT: src_h = v & 8'hFF;
      REG_DST_WIDTH:  dst_w = v & 11'h7FF;
      REG_DST_HEIGHT: dst_h = v & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned dw, input int unsigned dh);
    wait_idle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
  endtask

  task automatic random_phase(input int n);
    int unsigned r, x, y;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 35) queue_load($urandom_range(STORE_DEPTH - 1), $urandom);
      else begin
        // mostly inside the destination, a few anywhere
        if (r < 90 && dst_w != 0 && dst_h != 0) begin
          x = $urandom_range((dst_w > 1024 ? 1024 : dst_w) - 1);
          y = $urandom_range((dst_h > 1024 ? 1024 : dst_h) - 1);
        end else begin
          x = $urandom_range(1023);
          y = $urandom_range(1023);
        end
        queue_fetch(x, y);
      end
    end
  endtask

  // driver
  request_t cur;
  int unsigned in_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pixel(cur);
        holding = 1'b0;
      end
      if (!holding) begin
        if (in_gap > 0) in_gap--;
        else if (pending_requests.size() != 0) begin
          cur = pending_requests.pop_front();
          holding = 1'b1;
          in_gap = random_gap();
        end
      end
      in_valid <= holding;
      if (holding) begin
        kind <= cur.kind;
        load_index <= cur.lidx;
        pixel_in <= cur.pix;
        dst_x <= cur.dx;
        dst_y <= cur.dy;
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  res_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result pix=%h idx=%0d oor=%b",
                                     pixel_out, source_index, out_of_range);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want.pix || source_index !== want.idx ||
              out_of_range !== want.oor) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp pix=%h idx=%0d oor=%b, got pix=%h idx=%0d oor=%b",
                       want.pix, want.idx, want.oor, pixel_out, source_index, out_of_range);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = random_gap();
        out_stall <= 1'b0;
      end
      any_accept = (out_valid && !out_stall) || (in_valid && !in_stall) ||
                   (cfg_valid && cfg_ready);
      idle_cycles = any_accept ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_sizes(4, 4, 8, 8);
    queue_load(0, 32'h0000_0000);
    queue_load(5, 32'hFFFF_FFFF);
    queue_load(15, 32'hA5A5_5A5A);
    queue_load(STORE_DEPTH - 1, 32'h5A5A_A5A5);
    queue_fetch(0, 0);
    queue_fetch(7, 7);
    queue_fetch(2, 3);
    queue_fetch(7, 0);
    queue_fetch(8, 0);      // column just past the edge
    queue_fetch(0, 8);
    queue_fetch(1023, 1023);
    queue_fetch(3, 1023);
    wait_idle();
    write_reg(3'd5, 0);     // write to a register that does not exist
    wait_idle();
    write_reg(3'd7, 11'h7FF);
    queue_fetch(1, 1);
    set_sizes(0, 5, 3, 3);  // zero source width collapses to column zero
    queue_fetch(2, 2);
    queue_fetch(0, 1);
    set_sizes(4, 4, 0, 0);  // empty destination rejects every fetch
    queue_fetch(0, 0);
    queue_fetch(5, 9);

    set_sizes(1, 1, 1, 1);
    random_phase(100);
    set_sizes(128, 128, 1024, 1024);
    random_phase(250);
    set_sizes(128, 128, 1, 1);
    random_phase(100);
    set_sizes(7, 3, 1000, 13);
    random_phase(150);
    set_sizes(255, 255, 1024, 1024);  // some indexes land beyond the store
    random_phase(150);
    set_sizes(200, 90, 2047, 2047);
    random_phase(150);
    for (int p = 0; p < 3; p++) begin
      set_sizes($urandom_range(1, 128), $urandom_range(1, 128),
                $urandom_range(1, 1024), $urandom_range(1, 1024));
      random_phase(120);
    end

    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
